[src/utf8ct_pkg.sv]
`default_nettype none
package utf8ct_pkg;

  localparam int TableEntries = 64;
  localparam int CodeW = 21;

  // request opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_PAIR   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_BYTE   = 2'd3;

  // token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic             active;
    logic             add;   // insert when not found, else plain lookup
    logic             del;   // add: kind to write; lookup: kind of the hit
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] repl;  // add: code to write; lookup: replacement of the hit
    logic             hit;   // lookup: key found; add: key found or entry written
  } token_t;

  // finished code point from the decoder
  typedef struct packed {
    logic             finish;
    logic [CodeW-1:0] code;
    logic [31:0]      raw;
    logic [2:0]       len;
  } dec_result_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
  } enc_t;

  function automatic enc_t utf8ct_encode(logic [CodeW-1:0] r);
    enc_t e;
    e.bytes = '0;
    e.len   = 3'd1;
    priority if (r < 21'h80) begin
      e.bytes[7:0] = r[7:0];
      e.len        = 3'd1;
    end else if (r < 21'h800) begin
      e.bytes[7:0]  = {3'b110, r[10:6]};
      e.bytes[15:8] = {2'b10, r[5:0]};
      e.len         = 3'd2;
    end else if (r < 21'h10000) begin
      e.bytes[7:0]   = {4'b1110, r[15:12]};
      e.bytes[15:8]  = {2'b10, r[11:6]};
      e.bytes[23:16] = {2'b10, r[5:0]};
      e.len          = 3'd3;
    end else begin
      e.bytes[7:0]   = {5'b11110, r[20:18]};
      e.bytes[15:8]  = {2'b10, r[17:12]};
      e.bytes[23:16] = {2'b10, r[11:6]};
      e.bytes[31:24] = {2'b10, r[5:0]};
      e.len          = 3'd4;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

[src/utf8ct_cell.sv]
`default_nettype none
module utf8ct_cell (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     clear,
  input  wire utf8ct_pkg::token_t tin,
  output utf8ct_pkg::token_t      tout
);
  import utf8ct_pkg::*;

  logic             valid;
  logic             del;
  logic [CodeW-1:0] key;
  logic [CodeW-1:0] repl;
  token_t           tout_next;
  logic             wr;

  always_comb begin
    tout_next = tin;
    wr        = 1'b0;
    if (tin.active && !tin.hit) begin
      if (valid && key == tin.code) begin
        tout_next.hit = 1'b1;
        if (!tin.add) begin
          tout_next.del  = del;
          tout_next.repl = repl;
        end
      end else if (!valid && tin.add) begin
        // first free cell: every filled cell ahead was already checked
        wr            = 1'b1;
        tout_next.hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      tout.active <= 1'b0;
    end else begin
      tout <= tout_next;
      if (clear) begin
        valid <= 1'b0;
      end else if (wr) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      key  <= tin.code;
      repl <= tin.repl;
      del  <= tin.del;
    end
  end

endmodule
`default_nettype wire

[src/utf8ct_decoder.sv]
`default_nettype none
module utf8ct_decoder (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      clear,
  input  wire                      take,
  input  wire  [7:0]               data_byte,
  output utf8ct_pkg::dec_result_t  result
);
  import utf8ct_pkg::*;

  logic [CodeW-1:0] acc, acc_next;
  logic [1:0]       pending, pending_next;
  logic [31:0]      raw, raw_next;
  logic [2:0]       cnt, cnt_next;
  logic [CodeW-1:0] cont_acc;
  logic [31:0]      cont_raw;

  always_comb begin
    acc_next     = acc;
    pending_next = pending;
    raw_next     = raw;
    cnt_next     = cnt;
    result       = '0;
    cont_acc     = {acc[CodeW-7:0], data_byte[5:0]};
    cont_raw     = raw;
    cont_raw[{cnt[1:0], 3'b000} +: 8] = data_byte;
    if (clear) begin
      acc_next     = '0;
      pending_next = '0;
      raw_next     = '0;
      cnt_next     = '0;
    end else if (take) begin
      if (pending != 2'd0 && data_byte[7:6] == 2'b10) begin
        if (pending == 2'd1) begin
          result.finish = 1'b1;
          result.code   = cont_acc;
          result.raw    = cont_raw;
          result.len    = cnt + 3'd1;
          acc_next      = '0;
          pending_next  = '0;
          raw_next      = '0;
          cnt_next      = '0;
        end else begin
          acc_next     = cont_acc;
          raw_next     = cont_raw;
          cnt_next     = cnt + 3'd1;
          pending_next = pending - 2'd1;
        end
      end else begin
        // new code point, any partial one is dropped
        raw_next = {24'b0, data_byte};
        cnt_next = 3'd1;
        priority if (data_byte < 8'h80 || data_byte >= 8'hF8
                     || data_byte[7:6] == 2'b10) begin
          result.finish = 1'b1;
          result.code   = {13'b0, data_byte};
          result.raw    = {24'b0, data_byte};
          result.len    = 3'd1;
          acc_next      = '0;
          pending_next  = '0;
          raw_next      = '0;
          cnt_next      = '0;
        end else if (data_byte[7:5] == 3'b110) begin
          acc_next     = {16'b0, data_byte[4:0]};
          pending_next = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          acc_next     = {17'b0, data_byte[3:0]};
          pending_next = 2'd2;
        end else begin
          acc_next     = {18'b0, data_byte[2:0]};
          pending_next = 2'd3;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pending <= '0;
      raw     <= '0;
      cnt     <= '0;
    end else begin
      acc     <= acc_next;
      pending <= pending_next;
      raw     <= raw_next;
      cnt     <= cnt_next;
    end
  end

endmodule
`default_nettype wire

[src/utf8_char_translate_top.sv]
`default_nettype none
// a request that needs the table is registered into chain[0] and walks the cell chain,
//   one cell per cycle; its output bytes follow in the EMIT state once it leaves the chain
// busy stays high through the walk and the output bytes, so no new request is taken then;
//   clear and mid-sequence bytes do not make the block busy
// reset: synchronous, empties the table, the decoder and the overflow flag
// results are shown for one cycle each on out_strobe; the receiver cannot stall
module utf8_char_translate_top #(
  parameter int TABLE_ENTRIES = utf8ct_pkg::TableEntries
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  opcode,
  input  wire  [20:0] code_from,
  input  wire  [20:0] code_to,
  input  wire  [7:0]  data_byte,
  output logic        out_strobe,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        table_overflow
);
  import utf8ct_pkg::*;

  typedef enum logic [1:0] {IDLE, WALK, EMIT} state_t;

  state_t      state;
  token_t      chain [TABLE_ENTRIES+1];  // chain[0] is the injected request
  token_t      tok_out;
  dec_result_t dec;
  enc_t        enc;
  logic        accept;
  logic        clear_req;
  logic        byte_req;
  logic        overflow;
  logic [31:0] raw_hold;   // original bytes of the code point under lookup
  logic [2:0]  raw_len;
  logic [31:0] emit_buf;   // bytes still to send, next one in bits 7:0
  logic [2:0]  emit_left;

  assign busy      = (state != IDLE);
  assign accept    = start && !busy;
  assign clear_req = accept && (opcode == OP_CLEAR);
  assign byte_req  = accept && (opcode == OP_BYTE);

  // utf-8 decoder, reports a code point on its last byte
  utf8ct_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear_req),
    .take      (byte_req),
    .data_byte (data_byte),
    .result    (dec)
  );

  // table cells, entries fill from cell 0 upward
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    utf8ct_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .clear (clear_req),
      .tin   (chain[i]),
      .tout  (chain[i+1])
    );
  end

  assign tok_out = chain[TABLE_ENTRIES];
  assign enc     = utf8ct_encode(tok_out.repl);

  // output side comes straight from the emit shift buffer
  assign out_strobe     = (state == EMIT);
  assign out_byte       = emit_buf[7:0];
  assign out_last       = (emit_left == 3'd1);
  assign table_overflow = overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      chain[0].active <= 1'b0;
      overflow        <= 1'b0;
      emit_left       <= '0;
    end else begin
      // a token enters the chain for table requests and finished code points
      chain[0].active <= (state == IDLE) && start
                         && (opcode == OP_PAIR || opcode == OP_DELETE
                             || (opcode == OP_BYTE && dec.finish));
      unique case (state)
        IDLE: begin
          if (start) begin
            unique case (opcode)
              OP_CLEAR: begin
                overflow <= 1'b0;
              end
              OP_PAIR, OP_DELETE: begin
                // insert request, dropped on the way if the key is present
                chain[0].add    <= 1'b1;
                chain[0].del    <= (opcode == OP_DELETE);
                chain[0].code   <= code_from;
                chain[0].repl   <= (opcode == OP_DELETE) ? '0 : code_to;
                chain[0].hit    <= 1'b0;
                state           <= WALK;
              end
              OP_BYTE: begin
                if (dec.finish) begin
                  chain[0].add    <= 1'b0;
                  chain[0].del    <= 1'b0;
                  chain[0].code   <= dec.code;
                  chain[0].repl   <= '0;
                  chain[0].hit    <= 1'b0;
                  raw_hold        <= dec.raw;
                  raw_len         <= dec.len;
                  state           <= WALK;
                end
              end
              default: begin
                state <= IDLE;
              end
            endcase
          end
        end
        WALK: begin
          if (tok_out.active) begin
            if (tok_out.add) begin
              // insert fell off the end of a full table
              if (!tok_out.hit) begin
                overflow <= 1'b1;
              end
              state <= IDLE;
            end else if (tok_out.hit && tok_out.del) begin
              state <= IDLE;
            end else if (tok_out.hit) begin
              emit_buf  <= enc.bytes;
              emit_left <= enc.len;
              state     <= EMIT;
            end else begin
              emit_buf  <= raw_hold;
              emit_left <= raw_len;
              state     <= EMIT;
            end
          end
        end
        EMIT: begin
          emit_buf  <= {8'b0, emit_buf[31:8]};
          emit_left <= emit_left - 3'd1;
          if (emit_left == 3'd1) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the walking token only leaves the chain while waiting for it
  a_token_in_walk: assert property (@(posedge clk) disable iff (rst)
    tok_out.active |-> state == WALK)
    else $error("token left the chain outside the walk");

  // a table request always makes the block busy next cycle
  a_table_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_PAIR || opcode == OP_DELETE)) |=> busy)
    else $error("table request did not start a walk");

  // the last byte of a code point is never followed straight by another byte
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && out_last) |=> !out_strobe)
    else $error("output continued after the last byte");

  // the sticky flag drops only on a clear request or reset
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    $fell(table_overflow) |-> ($past(clear_req) || $past(rst)))
    else $error("overflow flag dropped without a clear");

  // a strobe never comes without busy held high
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    out_strobe |-> busy)
    else $error("result strobe while idle");
`endif

endmodule
`default_nettype wire

[dv/tb.sv]
module tb;
  import utf8ct_pkg::*;

  // kind of a mapping entry, mirrored in the predictor
  typedef enum logic [1:0] {
    ENT_EMPTY,
    ENT_REPLACE,
    ENT_DELETE
  } entry_kind_t;

  // one output byte as it should appear on the result ports
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } out_byte_t;

  // directed stimulus row; typed rows carry their known output bytes
  typedef struct packed {
    logic [1:0]  op;
    logic [20:0] from;
    logic [20:0] to;
    logic [7:0]  data;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] bytes;
  } stim_row_t;

  localparam int NumDirected = 27;
  localparam int RandomItems = 283;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = OP_CLEAR;
  logic [20:0] code_from = '0;
  logic [20:0] code_to = '0;
  logic [7:0]  data_byte = '0;
  logic        busy;
  logic        out_strobe;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        table_overflow;

  utf8_char_translate_top #(
    .TABLE_ENTRIES(TableEntries)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .code_from     (code_from),
    .code_to       (code_to),
    .data_byte     (data_byte),
    .out_strobe    (out_strobe),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .table_overflow(table_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: mapping entries, decoder and sticky overflow
  // ---------------------------------------------------------------------------
  logic [20:0] map_keys  [TableEntries];
  logic [20:0] map_repls [TableEntries];
  entry_kind_t map_kinds [TableEntries];
  int          map_used = 0;
  logic        map_ovf = 1'b0;
  logic [20:0] cp_acc = '0;
  int          cp_pending = 0;
  logic [31:0] cp_raw = '0;
  int          cp_raw_cnt = 0;

  out_byte_t   expected_bytes[$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          no_idle = 1'b0;
  logic [20:0] code_pool [16];
  int          pool_wr = 0;

  function automatic int lookup_code(input logic [20:0] code);
    int hit;
    hit = -1;
    for (int k = 0; k < map_used; k++) begin
      if (hit < 0 && map_kinds[k] != ENT_EMPTY && map_keys[k] == code) hit = k;
    end
    return hit;
  endfunction

  // plain utf-8 bit layout, first byte in bits 7:0, no range check
  function automatic int utf8_pack(input logic [20:0] r, output logic [31:0] enc);
    enc = '0;
    if (r < 21'h80) begin
      enc[7:0] = r[7:0];
      return 1;
    end else if (r < 21'h800) begin
      enc[15:0] = {2'b10, r[5:0], 3'b110, r[10:6]};
      return 2;
    end else if (r < 21'h10000) begin
      enc[23:0] = {2'b10, r[5:0], 2'b10, r[11:6], 4'b1110, r[15:12]};
      return 3;
    end
    enc = {2'b10, r[5:0], 2'b10, r[11:6], 2'b10, r[17:12], 5'b11110, r[20:18]};
    return 4;
  endfunction

  function automatic void reset_decoder();
    cp_acc     = '0;
    cp_pending = 0;
    cp_raw     = '0;
    cp_raw_cnt = 0;
  endfunction

  function automatic void add_mapping(input logic [20:0] key, input logic [20:0] repl,
                                      input entry_kind_t kind);
    if (lookup_code(key) >= 0) return;
    if (map_used >= TableEntries) begin
      map_ovf = 1'b1;
      return;
    end
    map_keys[map_used]  = key;
    map_repls[map_used] = repl;
    map_kinds[map_used] = kind;
    map_used++;
  endfunction

  // code point complete: replacement, original bytes, or nothing when deleted
  function automatic int emit_code_point(output logic [31:0] enc);
    int idx;
    int n;
    idx = lookup_code(cp_acc);
    enc = '0;
    if (idx >= 0 && map_kinds[idx] == ENT_DELETE) begin
      n = 0;
    end else if (idx >= 0) begin
      n = utf8_pack(map_repls[idx], enc);
    end else begin
      enc = cp_raw;
      n   = cp_raw_cnt;
    end
    reset_decoder();
    return n;
  endfunction

  // returns the number of output bytes one request causes
  function automatic int translate_request(input logic [1:0] op, input logic [20:0] from,
                                           input logic [20:0] to, input logic [7:0] b,
                                           output logic [31:0] enc);
    int n;
    n   = 0;
    enc = '0;
    case (op)
      OP_CLEAR: begin
        for (int k = 0; k < TableEntries; k++) map_kinds[k] = ENT_EMPTY;
        map_used = 0;
        map_ovf  = 1'b0;
        reset_decoder();
      end
      OP_PAIR:   add_mapping(from, to, ENT_REPLACE);
      OP_DELETE: add_mapping(from, '0, ENT_DELETE);
      default: begin
        if (cp_pending != 0 && b[7:6] == 2'b10) begin
          // continuation of the code point in flight
          cp_acc = {cp_acc[14:0], b[5:0]};
          if (cp_raw_cnt < 4) begin
            cp_raw[8*cp_raw_cnt +: 8] = b;
            cp_raw_cnt++;
          end
          cp_pending--;
          if (cp_pending == 0) n = emit_code_point(enc);
        end else begin
          // new code point, any partial one is dropped silently
          reset_decoder();
          cp_raw     = {24'h0, b};
          cp_raw_cnt = 1;
          if (b < 8'h80 || b >= 8'hF8 || b[7:6] == 2'b10) begin
            cp_acc = {13'h0, b};
            n = emit_code_point(enc);
          end else if (b[7:5] == 3'b110) begin
            cp_acc     = {16'h0, b[4:0]};
            cp_pending = 1;
          end else if (b[7:4] == 4'b1110) begin
            cp_acc     = {17'h0, b[3:0]};
            cp_pending = 2;
          end else begin
            cp_acc     = {18'h0, b[2:0]};
            cp_pending = 3;
          end
        end
      end
    endcase
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // drives one request, waits for the accepting edge and records what it should produce
  task automatic send(input logic [1:0] op, input logic [20:0] from, input logic [20:0] to,
                      input logic [7:0] b, input bit typed = 1'b0, input int typed_n = 0,
                      input logic [31:0] typed_bytes = '0);
    int          gap;
    int          n;
    logic [31:0] enc;
    out_byte_t   ob;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    code_from <= from;
    code_to   <= to;
    data_byte <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge; start stays high until the next call decides
    n = translate_request(op, from, to, b, enc);
    if (typed) begin
      n   = typed_n;
      enc = typed_bytes;
    end
    for (int k = 0; k < n; k++) begin
      ob.data = enc[8*k +: 8];
      ob.last = (k == n - 1);
      ob.ovf  = typed ? 1'b0 : map_ovf;
      expected_bytes.push_back(ob);
    end
    items_sent++;
  endtask

  // pooled keys, or random values from each utf-8 length class, 0, 10FFFF and surrogates
  function automatic logic [20:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return code_pool[$urandom_range(0, 15)];
      4:          return 21'($urandom_range(0, 'h7F));
      5:          return 21'($urandom_range('h80, 'h7FF));
      6:          return 21'($urandom_range('h800, 'hFFFF));
      7:          return 21'($urandom_range('h10000, 'h10FFFF));
      8:          return $urandom_range(0, 1) ? 21'h10FFFF : 21'h0;
      default:    return 21'($urandom_range('hD800, 'hDFFF));
    endcase
  endfunction

  task automatic add_random_entry();
    logic [20:0] key;
    key = pick_code();
    code_pool[pool_wr % 16] = key;
    pool_wr++;
    if ($urandom_range(0, 3) != 0) send(OP_PAIR, key, pick_code(), 8'($urandom));
    else send(OP_DELETE, key, 21'($urandom), 8'($urandom));
  endtask

  // full or cut-short byte sequence of one code point
  task automatic send_code_point(input logic [20:0] cp, input bit cut);
    logic [31:0] enc;
    int          len;
    len = utf8_pack(cp, enc);
    if (cut && len > 1) len = $urandom_range(1, len - 1);
    for (int k = 0; k < len; k++) send(OP_BYTE, 21'($urandom), 21'($urandom), enc[8*k +: 8]);
  endtask

  task automatic haystack_unit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) send_code_point(pick_code(), 1'b0);
    else if (r == 8) send_code_point(pick_code(), 1'b1);
    else send(OP_BYTE, 21'($urandom), 21'($urandom), 8'($urandom));
  endtask

  // fills the mapping two entries past capacity so the sticky flag comes up
  task automatic overflow_phase();
    logic [20:0] base;
    base = 21'($urandom_range(0, 'hF0000));
    send(OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < TableEntries + 2; i++) begin
      if ($urandom_range(0, 3) != 0) send(OP_PAIR, base + 21'(i * 1009), pick_code(), '0);
      else send(OP_DELETE, base + 21'(i * 1009), '0, '0);
    end
    // one repeated key while full: ignored, not an overflow
    send(OP_PAIR, base, pick_code(), '0);
    repeat (14) begin
      send_code_point(base + 21'($urandom_range(0, TableEntries + 1) * 1009), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker: one byte per strobe, no backpressure possible
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_output
    out_byte_t ob;
    if (!rst && out_strobe) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %h", out_byte);
        mismatches++;
      end else begin
        ob = expected_bytes.pop_front();
        if (out_byte !== ob.data) begin
          $error("out_byte expected %h actual %h", ob.data, out_byte);
          mismatches++;
        end
        if (out_last !== ob.last) begin
          $error("out_last expected %b actual %b", ob.last, out_last);
          mismatches++;
        end
        if (table_overflow !== ob.ovf) begin
          $error("table_overflow expected %b actual %b", ob.ovf, table_overflow);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [NumDirected];
  bit        filled = 1'b0;

  initial begin
    dir_rows = '{
      // bytes after reset pass through; stray continuation and 0xff are one-byte points
      '{OP_BYTE,   21'h0,      21'h0,      8'h41, 1'b1, 3'd1, 32'h41},
      '{OP_BYTE,   21'h0,      21'h0,      8'hFF, 1'b1, 3'd1, 32'hFF},
      '{OP_BYTE,   21'h0,      21'h0,      8'h80, 1'b1, 3'd1, 32'h80},
      // table build: repeats of a present key are ignored
      '{OP_PAIR,   21'h41,     21'h10FFFF, 8'h00, 1'b0, 3'd0, 32'h0},
      '{OP_PAIR,   21'h41,     21'h0,      8'h00, 1'b0, 3'd0, 32'h0},
      '{OP_DELETE, 21'hE9,     21'h0,      8'h00, 1'b0, 3'd0, 32'h0},
      '{OP_DELETE, 21'h41,     21'h1FFFFF, 8'h00, 1'b0, 3'd0, 32'h0},
      '{OP_PAIR,   21'h20AC,   21'h1FFFFF, 8'h00, 1'b0, 3'd0, 32'h0},
      '{OP_PAIR,   21'h0,      21'hD800,   8'h00, 1'b0, 3'd0, 32'h0},
      '{OP_PAIR,   21'h10FFFF, 21'h7FF,    8'h00, 1'b0, 3'd0, 32'h0},
      // 'A' -> top of the code space, four bytes
      '{OP_BYTE,   21'h0,      21'h0,      8'h41, 1'b1, 3'd4, 32'hBFBF8FF4},
      // deleted code point, nothing comes out
      '{OP_BYTE,   21'h0,      21'h0,      8'hC3, 1'b1, 3'd0, 32'h0},
      '{OP_BYTE,   21'h0,      21'h0,      8'hA9, 1'b1, 3'd0, 32'h0},
      // euro sign -> replacement beyond the unicode range
      '{OP_BYTE,   21'h0,      21'h0,      8'hE2, 1'b0, 3'd0, 32'h0},
      '{OP_BYTE,   21'h0,      21'h0,      8'h82, 1'b0, 3'd0, 32'h0},
      '{OP_BYTE,   21'h0,      21'h0,      8'hAC, 1'b1, 3'd4, 32'hBFBFBFF7},
      // four-byte input mapped to a two-byte output
      '{OP_BYTE,   21'h0,      21'h0,      8'hF4, 1'b0, 3'd0, 32'h0},
      '{OP_BYTE,   21'h0,      21'h0,      8'h8F, 1'b0, 3'd0, 32'h0},
      '{OP_BYTE,   21'h0,      21'h0,      8'hBF, 1'b0, 3'd0, 32'h0},
      '{OP_BYTE,   21'h0,      21'h0,      8'hBF, 1'b0, 3'd0, 32'h0},
      // overlong zero decodes to zero, mapped to a surrogate
      '{OP_BYTE,   21'h0,      21'h0,      8'hC0, 1'b0, 3'd0, 32'h0},
      '{OP_BYTE,   21'h0,      21'h0,      8'h80, 1'b0, 3'd0, 32'h0},
      // interrupted sequence: partial dropped, new byte decoded afresh
      '{OP_BYTE,   21'h0,      21'h0,      8'hF0, 1'b0, 3'd0, 32'h0},
      '{OP_BYTE,   21'h0,      21'h0,      8'h00, 1'b0, 3'd0, 32'h0},
      // clear in the middle of a sequence empties table and decoder
      '{OP_BYTE,   21'h0,      21'h0,      8'hE2, 1'b0, 3'd0, 32'h0},
      '{OP_CLEAR,  21'h1FFFFF, 21'h1FFFFF, 8'hFF, 1'b0, 3'd0, 32'h0},
      '{OP_BYTE,   21'h0,      21'h0,      8'h41, 1'b1, 3'd1, 32'h41}
    };
    for (int k = 0; k < 16; k++) code_pool[k] = 21'($urandom_range(0, 'h10FFFF));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumDirected; i++) begin
      send(dir_rows[i].op, dir_rows[i].from, dir_rows[i].to, dir_rows[i].data,
           dir_rows[i].typed, int'(dir_rows[i].n), dir_rows[i].bytes);
    end

    // random phases: optional clear, a few mappings, then mostly well-formed text; one overflow phase
    while (items_sent < NumDirected + RandomItems) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (!filled && items_sent > 90) begin
        overflow_phase();
        filled = 1'b1;
      end else begin
        if ($urandom_range(0, 2) == 0) send(OP_CLEAR, 21'($urandom), 21'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 5)) add_random_entry();
        repeat ($urandom_range(4, 14)) haystack_unit();
      end
    end
    start <= 1'b0;

    // drain, then leave room for any stray output
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TableEntries + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
src/utf8ct_pkg.sv
src/utf8ct_cell.sv
src/utf8ct_decoder.sv
src/utf8_char_translate_top.sv
dv/tb.sv
